FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on the clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("%m: assertion failed");

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("%m: assertion failed");

`endif

FILE: sv/its_pkg.sv
// ----------------------------------------------------------------------------
// Indent token scanner package
// Types and constants shared by the scanner and its level stack.
// ----------------------------------------------------------------------------
`default_nettype none

package its_pkg;

   // Number of indent levels the stack can hold, base level included.
   localparam int STACK_DEPTH = 32;
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int LEVEL_W     = 16;

   localparam logic [LEVEL_W-1:0] TAB_MAX = '1;

   // Characters that steer the scanner.
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;

   typedef enum logic [1:0] {
      KIND_NEWLINE = 2'd0,
      KIND_INDENT  = 2'd1,
      KIND_DEDENT  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_PUSH
   } state_type;

   // Write request into the level stack.
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   idx;
      logic [LEVEL_W-1:0] data;
   } stack_wr_type;

endpackage

`default_nettype wire

FILE: sv/its_level_stack.sv
// ----------------------------------------------------------------------------
// Indent level stack
// Register file of open indent levels with one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module its_level_stack (
   input  wire logic                        clock,
   input  wire its_pkg::stack_wr_type       wr,
   input  wire logic [its_pkg::IDX_W-1:0]   rd_idx,
   output logic      [its_pkg::LEVEL_W-1:0] rd_data
);
   import its_pkg::*;

   logic [LEVEL_W-1:0] level_ff [STACK_DEPTH];

   // Levels are written only on a push; the base entry is never written.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         level_ff[wr.idx] <= wr.data;
      end
   end

   // The base level always reads as zero, so it needs no reset.
   always_comb begin
      if (rd_idx == '0) begin
         rd_data = '0;
      end else begin
         rd_data = level_ff[rd_idx];
      end
   end

endmodule

`default_nettype wire

FILE: sv/indent_token_scanner.sv
// ----------------------------------------------------------------------------
// Indent token scanner
// Turns a byte stream into NEWLINE, INDENT and DEDENT tokens (tab offside rule).
// ----------------------------------------------------------------------------
// A byte is taken whenever the sequencer is idle and the result register is
// free, and a byte that makes at most one token writes that token into the
// result register, where it shows in the cycle after, so plain text runs at
// one byte per cycle while rsp_ready holds. A line that closes k levels, or
// the end of text with k open levels, gives one DEDENT word per pop after
// the byte is taken, then one INDENT word when an indent follows the pops;
// new bytes are refused meanwhile. This order follows from the single read
// port of the level stack and the one level comparator reused for every pop.
// Every word also waits for rsp_ready. No clearing pass is needed after reset.
`default_nettype none

`include "assert_macros.svh"

module indent_token_scanner (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_text_byte,
   input  wire logic                        req_end_of_text,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [1:0]                  rsp_token_kind,
   output logic      [its_pkg::LEVEL_W-1:0] rsp_indent_level,
   output logic                             rsp_last_token
);
   import its_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               newline_ff, newline_in;
   logic               cr_ff, cr_in;
   logic [LEVEL_W-1:0] tab_ff, tab_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           kind_ff, kind_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               last_ff, last_in;

   stack_wr_type       wr;
   logic [IDX_W-1:0]   rd_idx;
   logic [LEVEL_W-1:0] top;
   logic               out_free;
   logic               accept;
   logic               tab_gt, tab_lt;
   logic               can_push;
   logic               is_tab, is_lf, is_cr, is_nul, is_brk;
   logic               go_pop;
   logic               pop_more;

   its_level_stack u_stack (
      .clock   (clock),
      .wr      (wr),
      .rd_idx  (rd_idx),
      .rd_data (top)
   );

   // Handshake: a byte is taken only when the sequencer is idle and its token has a free slot.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // A pop reads the level below the current top; otherwise read the top.
   always_comb begin
      if (state_ff == ST_POP) begin
         rd_idx = IDX_W'(count_ff - CNT_W'(2));
      end else begin
         rd_idx = IDX_W'(count_ff - CNT_W'(1));
      end
   end

   // Shared level comparator and byte decode.
   assign tab_gt   = tab_ff > top;
   assign tab_lt   = tab_ff < top;
   assign can_push = count_ff < CNT_W'(STACK_DEPTH);
   assign is_tab   = req_text_byte == CHAR_TAB;
   assign is_lf    = req_text_byte == CHAR_LF;
   assign is_cr    = req_text_byte == CHAR_CR;
   assign is_nul   = req_text_byte == CHAR_NUL;
   assign is_brk   = is_lf || is_cr;
   assign pop_more = (count_ff > CNT_W'(2)) && tab_lt;

   // A byte starts a dedent run at end of text with open levels, or when a
   // line's first character sits left of the current level.
   always_comb begin
      go_pop = 1'b0;
      if (req_end_of_text) begin
         go_pop = count_ff > CNT_W'(1);
      end else if (newline_ff && (tab_ff != '0 || !is_cr)
                   && (tab_ff != '0 || !is_lf || !cr_ff)
                   && !is_tab && !is_brk && !is_nul) begin
         go_pop = tab_lt;
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && go_pop) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (out_free) begin
               priority if (pop_more) begin
                  state_in = ST_POP;
               end else if (tab_gt) begin
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Scanner state, stack writes and the result word.
   always_comb begin
      count_in     = count_ff;
      newline_in   = newline_ff;
      cr_in        = cr_ff;
      tab_in       = tab_ff;
      kind_in      = kind_ff;
      level_in     = level_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr.en        = 1'b0;
      wr.idx       = IDX_W'(count_ff);
      wr.data      = tab_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_end_of_text) begin
                  // End of text: clear line state, pops follow if any.
                  newline_in = 1'b0;
                  cr_in      = 1'b0;
                  tab_in     = '0;
               end else if (!newline_ff) begin
                  if (is_brk) begin
                     rsp_valid_in = 1'b1;
                     kind_in      = KIND_NEWLINE;
                     level_in     = top;
                     last_in      = 1'b1;
                     newline_in   = 1'b1;
                     cr_in        = is_cr;
                     tab_in       = '0;
                  end
               end else if (tab_ff == '0 && is_cr) begin
                  // Further carriage returns belong to the same break.
                  cr_in = 1'b1;
               end else if (tab_ff == '0 && is_lf && cr_ff) begin
                  // Line feed completes a CRLF pair.
                  cr_in = 1'b0;
               end else if (is_tab) begin
                  if (tab_ff != TAB_MAX) begin
                     tab_in = tab_ff + LEVEL_W'(1);
                  end
                  cr_in = 1'b0;
               end else if (is_brk) begin
                  // Blank line: a new break and a new NEWLINE word.
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_NEWLINE;
                  level_in     = top;
                  last_in      = 1'b1;
                  newline_in   = 1'b1;
                  cr_in        = is_cr;
                  tab_in       = '0;
               end else if (is_nul) begin
                  newline_in = 1'b0;
                  cr_in      = 1'b0;
                  tab_in     = '0;
               end else begin
                  // First character of a line: compare its indent.
                  newline_in = 1'b0;
                  cr_in      = 1'b0;
                  if (tab_gt) begin
                     wr.en        = can_push;
                     rsp_valid_in = 1'b1;
                     kind_in      = KIND_INDENT;
                     level_in     = can_push ? tab_ff : top;
                     last_in      = 1'b1;
                     count_in     = can_push ? count_ff + CNT_W'(1) : count_ff;
                     tab_in       = '0;
                  end else if (!tab_lt) begin
                     tab_in = '0;
                  end
               end
            end
         end
         ST_POP: begin
            // One level popped per word; the comparator sees the new top.
            if (out_free) begin
               count_in     = count_ff - CNT_W'(1);
               rsp_valid_in = 1'b1;
               kind_in      = KIND_DEDENT;
               level_in     = top;
               last_in      = !pop_more && !tab_gt;
               if (!pop_more && !tab_gt) begin
                  tab_in = '0;
               end
            end
         end
         ST_PUSH: begin
            // Indent that lies between two stacked levels.
            if (out_free) begin
               wr.en        = can_push;
               rsp_valid_in = 1'b1;
               kind_in      = KIND_INDENT;
               level_in     = can_push ? tab_ff : top;
               last_in      = 1'b1;
               count_in     = can_push ? count_ff + CNT_W'(1) : count_ff;
               tab_in       = '0;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CNT_W'(1);
         newline_ff   <= 1'b0;
         cr_ff        <= 1'b0;
         tab_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         newline_ff   <= newline_in;
         cr_ff        <= cr_in;
         tab_ff       <= tab_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      level_ff <= level_in;
      last_ff  <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_token_kind   = kind_ff;
   assign rsp_indent_level = level_ff;
   assign rsp_last_token   = last_ff;

   // The base level is never popped and the stack never overflows.
   `ASSERT_ALWAYS(a_count_range, count_ff >= CNT_W'(1) && count_ff <= CNT_W'(STACK_DEPTH))
   // A pop always has a level above the base to remove.
   `ASSERT_IMPLIES(a_pop_has_level, state_ff == ST_POP, count_ff >= CNT_W'(2))
   // A word that is not the last of its byte leaves the sequencer busy.
   `ASSERT_IMPLIES(a_busy_after_partial, rsp_valid_ff && !last_ff, state_ff != ST_IDLE)

endmodule

`default_nettype wire
